// File: rtl/core/bol_pkg.sv
package bol_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

    localparam int CMD_W  = 4;
    localparam int OPND_W = 32;
    localparam int STAT_W = 2;
    localparam int ELEM_W = 32;
    localparam int OCC_W  = 5;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [IDX_W-1:0]             t_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT    = 4'd0,
        CMD_PUSH_BACK     = 4'd1,
        CMD_POP_FRONT     = 4'd2,
        CMD_POP_BACK      = 4'd3,
        CMD_DELETE_ALL    = 4'd4,
        CMD_SORTED_INSERT = 4'd5,
        CMD_SORT          = 4'd6,
        CMD_CONTAINS      = 4'd7,
        CMD_DUMP          = 4'd8
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DELETE,
        S_SORT,
        S_DUMP
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LEFT,
        OP_RIGHT,
        OP_OPERAND,
        OP_CLEAR,
        OP_HEAD,
        OP_SORT_LO,
        OP_SORT_HI
    } t_cell_op;

    typedef struct packed {
        t_value val;
        logic   occ;
        logic   gt;
        logic   ge;
        logic   eq;
    } t_cell_out;

    typedef struct packed {
        t_status                  status;
        logic                     found;
        logic signed [ELEM_W-1:0] element_value;
        logic [OCC_W-1:0]         occupancy;
        logic                     last_of_run;
    } t_rsp;

endpackage

// File: rtl/core/bol_ifs.sv
interface bol_req_if;
    import bol_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [OPND_W-1:0] operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

interface bol_rsp_if;
    import bol_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [ELEM_W-1:0] element_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     last_of_run;

    modport source (output valid, output status, output found, output element_value,
                    output occupancy, output last_of_run, input ready);
    modport sink   (input valid, input status, input found, input element_value,
                    input occupancy, input last_of_run, output ready);
endinterface

// File: rtl/core/bol_cell.sv
module bol_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bol_pkg::t_cell_op   i_op,
    input  bol_pkg::t_value     i_operand,
    input  bol_pkg::t_value     i_head,
    input  bol_pkg::t_cell_out  i_left,
    input  bol_pkg::t_cell_out  i_right,
    output bol_pkg::t_cell_out  o_cell
);
    import bol_pkg::*;

    t_value r_val;
    t_value n_val;
    logic   r_occ;
    logic   n_occ;
    logic   w_gt;

    assign w_gt = $signed(r_val) > $signed(i_right.val);

    always_comb begin
        o_cell.val = r_val;
        o_cell.occ = r_occ;
        o_cell.gt  = w_gt;
        o_cell.ge  = r_occ & ($signed(r_val) >= $signed(i_operand));
        o_cell.eq  = r_occ & (r_val == i_operand);
    end

    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_LEFT: begin
                n_val = i_left.val;
                n_occ = i_left.occ;
            end
            OP_RIGHT: begin
                n_val = i_right.val;
                n_occ = i_right.occ;
            end
            OP_OPERAND: begin
                n_val = i_operand;
                n_occ = 1'b1;
            end
            OP_CLEAR: begin
                n_occ = 1'b0;
            end
            OP_HEAD: begin
                n_val = i_head;
            end
            OP_SORT_LO: begin
                if (r_occ && i_right.occ && w_gt) begin
                    n_val = i_right.val;
                end
            end
            OP_SORT_HI: begin
                if (r_occ && i_left.occ && i_left.gt) begin
                    n_val = i_left.val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: rtl/core/bounded_ordered_list_engine.sv
// Push, pop, sorted insert, contains and unknown commands, and delete-all or dump on
// an empty list, give their result in the cycle after the request. Delete-all removes
// matching elements one by one; sort runs odd-even exchange passes across the cell row;
// dump enters its state, then gives one element per cycle while taken.
// Throughput: one request at a time; the next request is taken at the earliest in the
// cycle the last result is taken.
// Reset: synchronous, active low; clears the occupied bits, the count and the output valid.
module bounded_ordered_list_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bol_req_if.sink   i_req,
    bol_rsp_if.source o_rsp
);
    import bol_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_count    r_count;
    t_count    n_count;
    t_idx      r_step;
    t_idx      n_step;
    t_value    r_operand;
    t_value    n_operand;
    logic      r_out_valid;
    t_rsp      r_out;
    t_rsp      n_out;
    logic      w_load;

    t_cell_out c_out   [CAPACITY];
    t_cell_out w_left  [CAPACITY];
    t_cell_out w_right [CAPACITY];
    t_cell_op  c_op    [CAPACITY];

    t_cmd      w_cmd;
    t_value    w_operand;
    logic      w_slot;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    logic      w_any_eq;
    logic      w_dump_last;
    logic      w_sort_last;
    t_value    w_back_val;

    logic [CAPACITY-1:0] w_cand;
    logic [CAPACITY-1:0] w_ins_before;
    logic [CAPACITY-1:0] w_del_before;
    logic [CAPACITY-1:0] w_last_cell;

    assign w_cmd       = t_cmd'(i_req.command);
    assign w_slot      = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_slot;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_operand   = (r_state == S_IDLE) ? t_value'($signed(i_req.operand_value)) : r_operand;
    assign w_full      = r_count == CNT_W'(CAPACITY);
    assign w_empty     = r_count == '0;
    assign w_dump_last = (CNT_W'(r_step) + CNT_W'(1)) == r_count;
    assign w_sort_last = r_step == IDX_W'(CAPACITY - 1);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_inner_l
            assign w_left[g] = c_out[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_inner_r
            assign w_right[g] = c_out[g+1];
        end

        bol_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (c_op[g]),
            .i_operand (w_operand),
            .i_head    (c_out[0].val),
            .i_left    (w_left[g]),
            .i_right   (w_right[g]),
            .o_cell    (c_out[g])
        );
    end

    always_comb begin
        w_any_eq   = 1'b0;
        w_back_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            unique case (w_cmd)
                CMD_PUSH_FRONT:    w_cand[i] = 1'b1;
                CMD_PUSH_BACK:     w_cand[i] = r_count == CNT_W'(i);
                default:           w_cand[i] = c_out[i].ge || (r_count == CNT_W'(i));
            endcase
            w_last_cell[i] = c_out[i].occ && !w_right[i].occ;
            w_any_eq       = w_any_eq | c_out[i].eq;
            if (w_last_cell[i]) begin
                w_back_val = w_back_val | c_out[i].val;
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            w_ins_before[i] = 1'b0;
            w_del_before[i] = 1'b0;
            for (int j = 0; j < CAPACITY; j++) begin
                if (j < i) begin
                    w_ins_before[i] = w_ins_before[i] | w_cand[j];
                    w_del_before[i] = w_del_before[i] | c_out[j].eq;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (w_cmd == CMD_DELETE_ALL && !w_empty) begin
                        n_state = S_DELETE;
                    end else if (w_cmd == CMD_SORT) begin
                        n_state = S_SORT;
                    end else if (w_cmd == CMD_DUMP && !w_empty) begin
                        n_state = S_DUMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DELETE: begin
                if (!w_any_eq) begin
                    n_state = S_IDLE;
                end
            end
            S_SORT: begin
                if (w_sort_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (w_slot && w_dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_step    = r_step;
        n_operand = r_operand;
        w_load    = 1'b0;
        n_out     = '0;
        n_out.status      = ST_OK;
        n_out.occupancy   = OCC_W'(r_count);
        n_out.last_of_run = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
            c_op[i] = OP_HOLD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_operand = w_operand;
                    n_step    = '0;
                    w_load    = 1'b1;
                    unique case (w_cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED_INSERT: begin
                            if (w_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (w_ins_before[i]) begin
                                        c_op[i] = OP_LEFT;
                                    end else if (w_cand[i]) begin
                                        c_op[i] = OP_OPERAND;
                                    end
                                end
                                n_count         = r_count + CNT_W'(1);
                                n_out.occupancy = OCC_W'(n_count);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    c_op[i] = OP_RIGHT;
                                end
                                n_count             = r_count - CNT_W'(1);
                                n_out.occupancy     = OCC_W'(n_count);
                                n_out.element_value = ELEM_W'(c_out[0].val);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (w_last_cell[i]) begin
                                        c_op[i] = OP_CLEAR;
                                    end
                                end
                                n_count             = r_count - CNT_W'(1);
                                n_out.occupancy     = OCC_W'(n_count);
                                n_out.element_value = ELEM_W'(w_back_val);
                            end
                        end
                        CMD_DELETE_ALL, CMD_DUMP: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                w_load = 1'b0;
                            end
                        end
                        CMD_SORT: begin
                            w_load = 1'b0;
                        end
                        CMD_CONTAINS: begin
                            n_out.found = w_any_eq;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DELETE: begin
                if (w_any_eq) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (w_del_before[i] || c_out[i].eq) begin
                            c_op[i] = OP_RIGHT;
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end else begin
                    w_load = 1'b1;
                end
            end
            S_SORT: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    c_op[i] = (1'(i % 2) == r_step[0]) ? OP_SORT_LO : OP_SORT_HI;
                end
                n_step = r_step + IDX_W'(1);
                w_load = w_sort_last;
            end
            S_DUMP: begin
                if (w_slot) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (w_right[i].occ) begin
                            c_op[i] = OP_RIGHT;
                        end else if (c_out[i].occ) begin
                            c_op[i] = OP_HEAD;
                        end
                    end
                    w_load              = 1'b1;
                    n_step              = r_step + IDX_W'(1);
                    n_out.element_value = ELEM_W'(c_out[0].val);
                    n_out.last_of_run   = w_dump_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_operand <= n_operand;
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.found         = r_out.found;
    assign o_rsp.element_value = r_out.element_value;
    assign o_rsp.occupancy     = r_out.occupancy;
    assign o_rsp.last_of_run   = r_out.last_of_run;

endmodule

// File: rtl/core/bol_checker.sv
module bol_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic [bol_pkg::STAT_W-1:0]        i_status,
    input logic                              i_found,
    input logic signed [bol_pkg::ELEM_W-1:0] i_element_value,
    input logic [bol_pkg::OCC_W-1:0]         i_occupancy,
    input logic                              i_last_of_run
);
    import bol_pkg::*;

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_FULL |-> i_occupancy == OCC_W'(CAPACITY))
        else $error("full status with occupancy below capacity");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_EMPTY |->
            i_occupancy == '0 && i_element_value == '0 && i_last_of_run)
        else $error("empty status with stale fields");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_found |-> i_status == ST_OK && i_last_of_run && i_element_value == '0)
        else $error("found set on a non-membership result");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status) && $stable(i_found)
            && $stable(i_element_value) && $stable(i_occupancy) && $stable(i_last_of_run))
        else $error("stalled result changed");

endmodule

bind bounded_ordered_list_engine bol_checker u_bol_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_found         (o_rsp.found),
    .i_element_value (o_rsp.element_value),
    .i_occupancy     (o_rsp.occupancy),
    .i_last_of_run   (o_rsp.last_of_run)
);
